>>> rtl/core/literal_watch_list_table_defines.svh
// ----------------------------------------------------------------------------
// Watch list table assertion macros
// Shared assertion forms for the checker attached to the top level.
// ----------------------------------------------------------------------------
`ifndef LITERAL_WATCH_LIST_TABLE_DEFINES_SVH
`define LITERAL_WATCH_LIST_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LWL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LWL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lwl_pkg.sv
// ----------------------------------------------------------------------------
// Watch list table package
// Sizes, command and status codes, and the result record.
// ----------------------------------------------------------------------------
package lwl_pkg;

    localparam int MAX_VARIABLES = 256;
    localparam int LIST_DEPTH    = 16;
    localparam int NUM_LISTS     = 2 * MAX_VARIABLES;
    localparam int NUM_ENTRIES   = NUM_LISTS * LIST_DEPTH;

    localparam int VAR_W    = 8;
    localparam int POS_W    = $clog2(LIST_DEPTH);
    localparam int LIST_W   = $clog2(NUM_LISTS);
    localparam int ENTRY_AW = $clog2(NUM_ENTRIES);
    localparam int COUNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 3;
    localparam int ID_W     = 16;
    localparam int WT_W     = 32;
    localparam int ACT_W    = 9;
    localparam int ENTRY_W  = ID_W + WT_W;

    localparam logic [ACT_W-1:0]   ACTIVE_RESET = ACT_W'(256);
    localparam logic [COUNT_W-1:0] COUNT_FULL   = COUNT_W'(LIST_DEPTH);

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_ID = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_AT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MEMBER = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_POS   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_VAR_RANGE = 3'd4;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               found;
        logic [COUNT_W-1:0] list_count;
        logic [ID_W-1:0]    entry_constraint;
        logic [WT_W-1:0]    entry_weight;
    } t_lwl_result;

endpackage

>>> rtl/core/lwl_cmd_if.sv
// ----------------------------------------------------------------------------
// Watch list command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface lwl_cmd_if;
    import lwl_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [VAR_W-1:0] variable;
    logic             negative;
    logic [ID_W-1:0]  constraint_id;
    logic [WT_W-1:0]  weight;
    logic [POS_W-1:0] position;

    modport source (
        output valid, cmd, variable, negative, constraint_id, weight, position,
        input  ready
    );
    modport sink (
        input  valid, cmd, variable, negative, constraint_id, weight, position,
        output ready
    );
endinterface

>>> rtl/core/lwl_rsp_if.sv
// ----------------------------------------------------------------------------
// Watch list response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface lwl_rsp_if;
    import lwl_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [COUNT_W-1:0] list_count;
    logic [ID_W-1:0]    entry_constraint;
    logic [WT_W-1:0]    entry_weight;

    modport source (
        output valid, status, found, list_count, entry_constraint, entry_weight,
        input  ready
    );
    modport sink (
        input  valid, status, found, list_count, entry_constraint, entry_weight,
        output ready
    );
endinterface

>>> rtl/core/lwl_out_stage.sv
// ----------------------------------------------------------------------------
// Watch list output register
// Holds one finished result until the response transfer completes.
// ----------------------------------------------------------------------------
module lwl_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  lwl_pkg::t_lwl_result i_result,
    output logic                 o_free,
    lwl_rsp_if.source            o_rsp
);
    import lwl_pkg::*;

    logic        r_valid;
    t_lwl_result r_data;

    assign o_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_rsp.valid            = r_valid;
    assign o_rsp.status           = r_data.status;
    assign o_rsp.found            = r_data.found;
    assign o_rsp.list_count       = r_data.list_count;
    assign o_rsp.entry_constraint = r_data.entry_constraint;
    assign o_rsp.entry_weight     = r_data.entry_weight;

endmodule

>>> rtl/core/literal_watch_list_table.sv
// One command in flight. Out-of-range commands go straight to the done state;
// add and clear pass through the count read state; read and remove at position add
// a data read or move state. Remove by id and membership test scan one entry a cycle
// (up to 16) after the count read. A stalled result holds the next command.
// Reset: synchronous; a clearing pass then zeroes the 512 list counts
// with command ready low. active_variables resets to 256.
// ----------------------------------------------------------------------------
// Literal watch list table
// Per-literal bounded watcher lists in block memory, read-modify-write control.
// ----------------------------------------------------------------------------
module literal_watch_list_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lwl_pkg::ACT_W-1:0]  i_cfg_wdata,
    lwl_cmd_if.sink                    i_cmd,
    lwl_rsp_if.source                  o_rsp
);
    import lwl_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CNT   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_MOVE  = 7'b0010000,
        S_RDATA = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [LIST_W-1:0]  r_clr_idx;
    logic [ACT_W-1:0]   r_active_vars;

    logic [CMD_W-1:0]   r_cmd;
    logic [LIST_W-1:0]  r_list;
    logic [ID_W-1:0]    r_id;
    logic [WT_W-1:0]    r_wt;
    logic [POS_W-1:0]   r_pos;
    logic [COUNT_W-1:0] r_n, n_n;
    logic [POS_W-1:0]   r_idx, n_idx;
    logic [POS_W-1:0]   r_hole, n_hole;
    t_lwl_result        r_res, n_res;

    // count memory
    logic [COUNT_W-1:0] m_counts [NUM_LISTS];
    logic               cnt_we;
    logic [LIST_W-1:0]  cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [LIST_W-1:0]  cnt_raddr;
    logic [COUNT_W-1:0] r_cnt_rdata;

    // watcher memory
    logic [ENTRY_W-1:0]  m_store [NUM_ENTRIES];
    logic                st_we;
    logic [ENTRY_AW-1:0] st_waddr;
    logic [ENTRY_W-1:0]  st_wdata;
    logic [ENTRY_AW-1:0] st_raddr;
    logic [ENTRY_W-1:0]  r_st_rdata;

    logic               accept;
    logic               in_range;
    logic               out_free;
    logic               out_load;
    logic [COUNT_W-1:0] cnt_last;
    logic [POS_W-1:0]   scan_last;
    logic               hit;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    // variable is below MAX_VARIABLES by width, so only the register bounds it
    assign in_range    = ({1'b0, i_cmd.variable} < r_active_vars);
    assign cnt_raddr   = {i_cmd.variable, i_cmd.negative};
    assign cnt_last    = r_cnt_rdata - COUNT_W'(1);
    assign scan_last   = POS_W'(r_n - COUNT_W'(1));
    assign hit         = (r_st_rdata[ENTRY_W-1:WT_W] == r_id);
    assign out_load    = (r_state == S_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_vars <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active_vars <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + LIST_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd.cmd;
            r_list <= {i_cmd.variable, i_cmd.negative};
            r_id   <= i_cmd.constraint_id;
            r_wt   <= i_cmd.weight;
            r_pos  <= i_cmd.position;
        end
        r_n    <= n_n;
        r_idx  <= n_idx;
        r_hole <= n_hole;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_counts[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rdata <= m_counts[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            m_store[st_waddr] <= st_wdata;
        end
        r_st_rdata <= m_store[st_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_idx     = r_idx;
        n_hole    = r_hole;
        n_res     = r_res;
        cnt_we    = 1'b0;
        cnt_waddr = r_list;
        cnt_wdata = '0;
        st_we     = 1'b0;
        st_waddr  = {r_list, r_hole};
        st_wdata  = r_st_rdata;
        st_raddr  = {r_list, r_pos};

        unique case (r_state)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr_idx;
                if (r_clr_idx == LIST_W'(NUM_LISTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    if (in_range) begin
                        n_state = S_CNT;
                    end else begin
                        n_res.status = STAT_VAR_RANGE;
                        n_state      = S_DONE;
                    end
                end
            end
            S_CNT: begin
                n_n              = r_cnt_rdata;
                n_res.list_count = r_cnt_rdata;
                n_state          = S_DONE;
                unique case (r_cmd) inside
                    CMD_ADD: begin
                        if (r_cnt_rdata >= COUNT_FULL) begin
                            n_res.status = STAT_FULL;
                        end else begin
                            st_we            = 1'b1;
                            st_waddr         = {r_list, POS_W'(r_cnt_rdata)};
                            st_wdata         = {r_id, r_wt};
                            cnt_we           = 1'b1;
                            cnt_wdata        = r_cnt_rdata + COUNT_W'(1);
                            n_res.list_count = r_cnt_rdata + COUNT_W'(1);
                        end
                    end
                    CMD_DEL_ID, CMD_MEMBER: begin
                        if (r_cnt_rdata == '0) begin
                            n_res.status = (r_cmd == CMD_DEL_ID) ? STAT_NOT_FOUND : STAT_OK;
                        end else begin
                            st_raddr = {r_list, POS_W'(0)};
                            n_idx    = '0;
                            n_state  = S_SCAN;
                        end
                    end
                    CMD_DEL_AT: begin
                        if ({1'b0, r_pos} >= r_cnt_rdata) begin
                            n_res.status = STAT_BAD_POS;
                        end else begin
                            // fetch the last entry to fill the hole
                            st_raddr = {r_list, POS_W'(cnt_last)};
                            n_hole   = r_pos;
                            n_state  = S_MOVE;
                        end
                    end
                    CMD_CLEAR: begin
                        cnt_we           = 1'b1;
                        cnt_wdata        = '0;
                        n_res.list_count = '0;
                    end
                    CMD_READ: begin
                        if ({1'b0, r_pos} >= r_cnt_rdata) begin
                            n_res.status = STAT_BAD_POS;
                        end else begin
                            st_raddr = {r_list, r_pos};
                            n_state  = S_RDATA;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // r_st_rdata holds entry r_idx; next address goes out this cycle
                st_raddr = {r_list, r_idx + POS_W'(1)};
                if (hit) begin
                    if (r_cmd == CMD_DEL_ID) begin
                        st_raddr = {r_list, scan_last};
                        n_hole   = r_idx;
                        n_state  = S_MOVE;
                    end else begin
                        n_res.found = 1'b1;
                        n_state     = S_DONE;
                    end
                end else if (r_idx == scan_last) begin
                    n_res.status = (r_cmd == CMD_DEL_ID) ? STAT_NOT_FOUND : STAT_OK;
                    n_state      = S_DONE;
                end else begin
                    n_idx = r_idx + POS_W'(1);
                end
            end
            S_MOVE: begin
                st_we            = 1'b1;
                st_waddr         = {r_list, r_hole};
                st_wdata         = r_st_rdata;
                cnt_we           = 1'b1;
                cnt_wdata        = r_n - COUNT_W'(1);
                n_res.list_count = r_n - COUNT_W'(1);
                n_state          = S_DONE;
            end
            S_RDATA: begin
                n_res.entry_constraint = r_st_rdata[ENTRY_W-1:WT_W];
                n_res.entry_weight     = r_st_rdata[WT_W-1:0];
                n_state                = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    lwl_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (r_res),
        .o_free   (out_free),
        .o_rsp    (o_rsp)
    );

endmodule

>>> rtl/core/lwl_chk.sv
// ----------------------------------------------------------------------------
// Watch list table checker
// Port-level assertions on the command and response channels.
// ----------------------------------------------------------------------------
`include "literal_watch_list_table_defines.svh"

module lwl_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cmd_valid,
    input logic                          i_cmd_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [lwl_pkg::STAT_W-1:0]    i_rsp_status,
    input logic                          i_rsp_found,
    input logic [lwl_pkg::COUNT_W-1:0]   i_rsp_list_count,
    input logic [lwl_pkg::ID_W-1:0]      i_rsp_entry_constraint,
    input logic [lwl_pkg::WT_W-1:0]      i_rsp_entry_weight
);
    import lwl_pkg::*;

    // one command at a time: ready drops right after a command transfer
    `LWL_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready, !i_cmd_ready, "command accepted while another is in flight")

    `LWL_ASSERT_NOW(a_entry_only_ok, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status != STAT_OK), (i_rsp_entry_constraint == '0) && (i_rsp_entry_weight == '0), "entry fields set on a failed command")

    `LWL_ASSERT_NOW(a_found_nonempty, i_clk, i_rst_n, i_rsp_valid && i_rsp_found, (i_rsp_status == STAT_OK) && (i_rsp_list_count != '0), "found reported on an empty list or failed command")

    `LWL_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_list_count), "stalled result changed")

endmodule

bind literal_watch_list_table lwl_chk u_lwl_chk (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_cmd_valid            (i_cmd.valid),
    .i_cmd_ready            (i_cmd.ready),
    .i_rsp_valid            (o_rsp.valid),
    .i_rsp_ready            (o_rsp.ready),
    .i_rsp_status           (o_rsp.status),
    .i_rsp_found            (o_rsp.found),
    .i_rsp_list_count       (o_rsp.list_count),
    .i_rsp_entry_constraint (o_rsp.entry_constraint),
    .i_rsp_entry_weight     (o_rsp.entry_weight)
);
